/* hw/rtl/iirdf2t_pkg.sv */
// Shared types, constants and the control program of the biquad filter.
package iirdf2t_pkg;

  localparam int CHANNELS_DEF = 4;
  localparam int CHAN_W       = 2;
  localparam int SAMPLE_W     = 32;
  localparam int COEF_W       = 32;
  localparam int DLY_W        = 48;
  localparam int ACC_W        = 56;
  localparam int PROD_W       = SAMPLE_W + COEF_W;
  localparam int FRAC_SHIFT   = 12;
  localparam int Y_SHIFT      = 16;
  localparam int NUM_REGS     = 7;
  localparam int CFG_IDX_W    = 3;
  localparam int STEP_W       = 4;

  localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(32'sd268435456);

  // Program addresses
  localparam logic [STEP_W-1:0] STEP_IDLE = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_SEED = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_MAIN = STEP_W'(3);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(8);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0, REG_B1, REG_B2, REG_A1, REG_A2, REG_G0, REG_G1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BR_NEXT,      // fall through to the next step
    BR_WAIT_IN,   // hold until an item arrives, jump to target when no run start
    BR_WAIT_OUT   // hold until the result register is free, then jump to target
  } br_t;

  typedef enum logic {
    SRC_X,
    SRC_Y
  } src_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SEED,   // saturated product, only on the first item of a run
    OP_ADD,
    OP_SUB,
    OP_LOAD,
    OP_XADD    // other accumulator plus product
  } acc_op_t;

  typedef struct packed {
    br_t               br;
    logic [STEP_W-1:0] tgt;
    logic              mul_en;
    cfg_reg_t          mul_coef;
    src_t              mul_src;
    acc_op_t           d0_op;
    acc_op_t           d1_op;
    logic              y_en;
  } ctl_t;

  // Control store. The product of a step is used by the step after it.
  function automatic ctl_t ucode(input logic [STEP_W-1:0] step);
    ctl_t w;
    w = '{br: BR_WAIT_IN, tgt: STEP_MAIN, mul_en: 1'b0, mul_coef: REG_B0,
          mul_src: SRC_X, d0_op: OP_HOLD, d1_op: OP_HOLD, y_en: 1'b0};
    case (step)
      4'd1: begin
        w.br = BR_NEXT; w.mul_en = 1'b1; w.mul_coef = REG_G0;
      end
      4'd2: begin
        w.br = BR_NEXT; w.mul_en = 1'b1; w.mul_coef = REG_G1; w.d0_op = OP_SEED;
      end
      4'd3: begin
        w.br = BR_NEXT; w.mul_en = 1'b1; w.mul_coef = REG_B0; w.d1_op = OP_SEED;
      end
      4'd4: begin
        w.br = BR_NEXT; w.mul_en = 1'b1; w.mul_coef = REG_B1; w.d0_op = OP_ADD;
      end
      4'd5: begin
        w.br = BR_NEXT; w.mul_en = 1'b1; w.mul_coef = REG_B2;
        w.y_en = 1'b1; w.d0_op = OP_XADD;
      end
      4'd6: begin
        w.br = BR_NEXT; w.mul_en = 1'b1; w.mul_coef = REG_A1; w.mul_src = SRC_Y;
        w.d1_op = OP_LOAD;
      end
      4'd7: begin
        w.br = BR_NEXT; w.mul_en = 1'b1; w.mul_coef = REG_A2; w.mul_src = SRC_Y;
        w.d0_op = OP_SUB;
      end
      4'd8: begin
        w.br = BR_WAIT_OUT; w.tgt = STEP_IDLE; w.d1_op = OP_SUB;
      end
      default: begin
        w.br = BR_WAIT_IN;
      end
    endcase
    return w;
  endfunction

endpackage

/* hw/rtl/iirdf2t_if.sv */
// Valid/ready channel interfaces for filter input and filtered output items.
interface iirdf2t_in_if;
  logic                                    valid;
  logic                                    ready;
  logic [iirdf2t_pkg::CHAN_W-1:0]          chan;
  logic                                    run_start;
  logic signed [iirdf2t_pkg::SAMPLE_W-1:0] sample_in;

  modport source (output valid, chan, run_start, sample_in, input ready);
  modport sink   (input valid, chan, run_start, sample_in, output ready);
endinterface

interface iirdf2t_out_if;
  logic                                    valid;
  logic                                    ready;
  logic [iirdf2t_pkg::CHAN_W-1:0]          chan_out;
  logic signed [iirdf2t_pkg::SAMPLE_W-1:0] sample_out;

  modport source (output valid, chan_out, sample_out, input ready);
  modport sink   (input valid, chan_out, sample_out, output ready);
endinterface

/* hw/rtl/iirdf2t_dp.sv */
// Datapath: one shared multiplier, two delay accumulators and the output word.
module iirdf2t_dp (
  input  logic                                    clk,
  input  iirdf2t_pkg::ctl_t                       ctl,
  input  logic                                    adv,
  input  logic                                    ld,
  input  logic                                    seed_ok,
  input  logic signed [iirdf2t_pkg::SAMPLE_W-1:0] x,
  input  logic signed [iirdf2t_pkg::COEF_W-1:0]   coef,
  input  logic signed [iirdf2t_pkg::DLY_W-1:0]    d0_ld,
  input  logic signed [iirdf2t_pkg::DLY_W-1:0]    d1_ld,
  output logic signed [iirdf2t_pkg::SAMPLE_W-1:0] y,
  output logic signed [iirdf2t_pkg::DLY_W-1:0]    wb0,
  output logic signed [iirdf2t_pkg::DLY_W-1:0]    wb1
);

  localparam int ACC_W  = iirdf2t_pkg::ACC_W;
  localparam int DLY_W  = iirdf2t_pkg::DLY_W;
  localparam int PROD_W = iirdf2t_pkg::PROD_W;
  localparam int SMP_W  = iirdf2t_pkg::SAMPLE_W;
  localparam int FS     = iirdf2t_pkg::FRAC_SHIFT;
  localparam int YS     = iirdf2t_pkg::Y_SHIFT;
  localparam int P_W    = PROD_W - FS;
  localparam int YW     = ACC_W - YS;

  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  d0_r, d0_nxt, d1_r, d1_nxt, p;
  logic signed [SMP_W-1:0]  y_r, y_nxt, mul_op;

  function automatic logic signed [DLY_W-1:0] sat48(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-DLY_W:0] top;
    top = v[ACC_W-1:DLY_W-1];
    if ((&top) || !(|top)) return v[DLY_W-1:0];
    return v[ACC_W-1] ? {1'b1, {(DLY_W-1){1'b0}}} : {1'b0, {(DLY_W-1){1'b1}}};
  endfunction

  function automatic logic signed [SMP_W-1:0] sat32(input logic signed [YW-1:0] v);
    logic [YW-SMP_W:0] top;
    top = v[YW-1:SMP_W-1];
    if ((&top) || !(|top)) return v[SMP_W-1:0];
    return v[YW-1] ? {1'b1, {(SMP_W-1){1'b0}}} : {1'b0, {(SMP_W-1){1'b1}}};
  endfunction

  function automatic logic signed [ACC_W-1:0] acc_step(
    input iirdf2t_pkg::acc_op_t     op,
    input logic signed [ACC_W-1:0] cur,
    input logic signed [ACC_W-1:0] other,
    input logic signed [ACC_W-1:0] pv,
    input logic                    sok
  );
    logic signed [DLY_W-1:0] s;
    s = sat48(pv);
    case (op)
      iirdf2t_pkg::OP_HOLD: return cur;
      iirdf2t_pkg::OP_SEED: return sok ? {{(ACC_W-DLY_W){s[DLY_W-1]}}, s} : cur;
      iirdf2t_pkg::OP_ADD:  return cur + pv;
      iirdf2t_pkg::OP_SUB:  return cur - pv;
      iirdf2t_pkg::OP_LOAD: return pv;
      iirdf2t_pkg::OP_XADD: return other + pv;
      default:              return cur;
    endcase
  endfunction

  // Product rescaled to the delay format, rounding toward minus infinity
  assign p = {{(ACC_W-P_W){prod_r[PROD_W-1]}}, prod_r[PROD_W-1:FS]};

  assign mul_op = (ctl.mul_src == iirdf2t_pkg::SRC_Y) ? y_r : x;

  always_comb begin
    prod_nxt = prod_r;
    y_nxt    = y_r;
    d0_nxt   = d0_r;
    d1_nxt   = d1_r;
    if (ld) begin
      d0_nxt = {{(ACC_W-DLY_W){d0_ld[DLY_W-1]}}, d0_ld};
      d1_nxt = {{(ACC_W-DLY_W){d1_ld[DLY_W-1]}}, d1_ld};
    end else if (adv) begin
      if (ctl.mul_en) prod_nxt = coef * mul_op;
      if (ctl.y_en) y_nxt = sat32(d0_r[ACC_W-1:YS]);
      d0_nxt = acc_step(ctl.d0_op, d0_r, d1_r, p, seed_ok);
      d1_nxt = acc_step(ctl.d1_op, d1_r, d0_r, p, seed_ok);
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    y_r    <= y_nxt;
    d0_r   <= d0_nxt;
    d1_r   <= d1_nxt;
  end

  assign y   = y_r;
  assign wb0 = sat48(d0_nxt);
  assign wb1 = sat48(d1_nxt);

endmodule

/* hw/rtl/iir_df2t_multichannel_filter.sv */
// Top level: multichannel second-order IIR filter, transposed direct form II.
//
// Items enter on in_ch (chan, run_start, sample_in, Q16.16) and each gives
// exactly one item on out_ch (chan_out, sample_out, saturated Q16.16).
// A step counter walks a small control program; every step issues at most one
// product on the single shared 32x32 multiplier, and that multiplier sets the
// pace. An item without run_start runs six program steps, from the main step
// to the last, where the result register loads; the next item is taken only
// back at the idle step; with run_start the two seeding products run first.
// in_ch.ready is high only while the program sits at its idle step.
// The result register frees the program as soon as the last step can hand off;
// while out_ch is stalled with a result pending, the program holds at its last
// step and no new item is taken.
// Channels at or above CHANNELS give a zero sample and leave all delays alone.
// The user must write coefficients through cfg_we/cfg_index/cfg_wdata only
// while idle; the block itself does not enforce it.
// Reset (rst_n low, synchronous) clears the delays of every channel, sets b0
// to 1.0 and every other register to zero, and empties the result register.
module iir_df2t_multichannel_filter #(
  parameter int CHANNELS = iirdf2t_pkg::CHANNELS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  iirdf2t_in_if.sink                             in_ch,
  iirdf2t_out_if.source                          out_ch,
  input  logic                                   cfg_we,
  input  logic [iirdf2t_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [iirdf2t_pkg::COEF_W-1:0]         cfg_wdata
);

  localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int STEP_W    = iirdf2t_pkg::STEP_W;
  localparam int DLY_W     = iirdf2t_pkg::DLY_W;
  localparam int SMP_W     = iirdf2t_pkg::SAMPLE_W;
  localparam int CHAN_W    = iirdf2t_pkg::CHAN_W;
  localparam int NREG      = iirdf2t_pkg::NUM_REGS;
  localparam int CFG_IDX_W = iirdf2t_pkg::CFG_IDX_W;

  logic signed [iirdf2t_pkg::COEF_W-1:0] coef_r [NREG];
  logic signed [DLY_W-1:0] dly0_r [CHANNELS];
  logic signed [DLY_W-1:0] dly1_r [CHANNELS];

  logic [STEP_W-1:0]       step_r, step_nxt;
  iirdf2t_pkg::ctl_t       ctl;
  logic                    adv, in_acc, ch_ok, wb_en;
  logic [CH_IDX_W-1:0]     in_idx, idx_r;
  logic [CHAN_W-1:0]       chan_r;
  logic                    start_r, ch_ok_r;
  logic signed [SMP_W-1:0] x_r;
  logic signed [DLY_W-1:0] d0_ld, d1_ld, wb0, wb1;
  logic signed [SMP_W-1:0] y;
  logic                    out_valid_r;
  logic [CHAN_W-1:0]       out_chan_r;
  logic signed [SMP_W-1:0] out_sample_r;

  // Sequencer
  assign ctl          = iirdf2t_pkg::ucode(step_r);
  assign in_ch.ready  = (ctl.br == iirdf2t_pkg::BR_WAIT_IN);
  assign in_acc       = in_ch.valid && in_ch.ready;

  always_comb begin
    adv      = 1'b0;
    step_nxt = step_r;
    case (ctl.br)
      iirdf2t_pkg::BR_NEXT: begin
        adv      = 1'b1;
        step_nxt = step_r + STEP_W'(1);
      end
      iirdf2t_pkg::BR_WAIT_IN: begin
        adv = in_acc;
        if (in_acc) step_nxt = in_ch.run_start ? step_r + STEP_W'(1) : ctl.tgt;
      end
      iirdf2t_pkg::BR_WAIT_OUT: begin
        adv = !out_valid_r || out_ch.ready;
        if (adv) step_nxt = ctl.tgt;
      end
      default: begin
        step_nxt = iirdf2t_pkg::STEP_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= iirdf2t_pkg::STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NREG; i++)
        coef_r[i] <= (i == int'(iirdf2t_pkg::REG_B0)) ? iirdf2t_pkg::COEF_ONE : '0;
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NREG))) begin
      coef_r[cfg_index] <= cfg_wdata;
    end
  end

  // Item capture and delay read
  assign ch_ok  = ({{(32-CHAN_W){1'b0}}, in_ch.chan} < 32'(CHANNELS));
  assign in_idx = CH_IDX_W'(in_ch.chan);
  assign d0_ld  = ch_ok ? dly0_r[in_idx] : '0;
  assign d1_ld  = ch_ok ? dly1_r[in_idx] : '0;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      chan_r  <= in_ch.chan;
      idx_r   <= in_idx;
      start_r <= in_ch.run_start;
      ch_ok_r <= ch_ok;
      x_r     <= in_ch.sample_in;
    end
  end

  iirdf2t_dp u_dp (
    .clk     (clk),
    .ctl     (ctl),
    .adv     (adv),
    .ld      (in_acc),
    .seed_ok (start_r),
    .x       (x_r),
    .coef    (coef_r[ctl.mul_coef]),
    .d0_ld   (d0_ld),
    .d1_ld   (d1_ld),
    .y       (y),
    .wb0     (wb0),
    .wb1     (wb1)
  );

  // Delay write-back at the last step
  assign wb_en = (ctl.br == iirdf2t_pkg::BR_WAIT_OUT) && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        dly0_r[i] <= '0;
        dly1_r[i] <= '0;
      end
    end else if (wb_en && ch_ok_r) begin
      dly0_r[idx_r] <= wb0;
      dly1_r[idx_r] <= wb1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (wb_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_en) begin
      out_chan_r   <= chan_r;
      out_sample_r <= ch_ok_r ? y : '0;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.chan_out   = out_chan_r;
  assign out_ch.sample_out = out_sample_r;

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= iirdf2t_pkg::STEP_LAST)
    else $error("step counter left the program");

  a_skip_seed: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_ch.run_start) |=> (step_r == iirdf2t_pkg::STEP_MAIN))
    else $error("item without run start did not skip seeding");

  a_seed_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.run_start) |=> (step_r == iirdf2t_pkg::STEP_SEED))
    else $error("run start item did not enter seeding");

  a_out_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(step_r) == iirdf2t_pkg::STEP_LAST))
    else $error("result posted outside the last step");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == iirdf2t_pkg::STEP_LAST && out_valid_r && !out_ch.ready)
      |=> (step_r == iirdf2t_pkg::STEP_LAST))
    else $error("program left the last step while the result was stalled");

endmodule
